// File: src/ctcgd_pkg.sv
// Shared types and constants of the CTC greedy decoder.
package ctcgd_pkg;

    // Fixed field widths of the stream items.
    localparam int SCORE_W   = 16;
    localparam int STEPS_W   = 9;
    localparam int CLASS_W   = 7;
    localparam int REG_W     = 8;
    localparam int CFG_IDX_W = 3;

    // Largest class count the class index field can carry.
    localparam int CLASS_LIMIT = 128;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CLASSES    = 3'd0,
        CFG_PADDING_INDEX  = 3'd1,
        CFG_IGNORE_INDEX_A = 3'd2,
        CFG_IGNORE_INDEX_B = 3'd3,
        CFG_IGNORE_INDEX_C = 3'd4
    } cfg_index_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [REG_W-1:0] num_classes;
        logic [REG_W-1:0] padding_index;
        logic [REG_W-1:0] ignore_index_a;
        logic [REG_W-1:0] ignore_index_b;
        logic [REG_W-1:0] ignore_index_c;
    } cfg_t;

    // One input score item.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               sequence_start;
        logic [STEPS_W-1:0] decode_steps;
    } item_t;

    // One decoded result item.
    typedef struct packed {
        logic [CLASS_W-1:0] class_index;
        logic [SCORE_W-1:0] class_score;
    } result_t;

endpackage

// File: src/ctc_greedy_decoder_top.sv
// Top level of the CTC greedy decoder: stream registers and configuration.
//
// Channel  Direction  Signals                               Contents
// s_*      in         s_tvalid s_tready s_tdata s_tuser     one class score per transaction
// m_*      out        m_tvalid m_tready m_tdata             one decoded class per transaction
// cfg_*    in         cfg_valid cfg_ready cfg_index cfg_data register writes, always ready
//
// One score is taken per cycle while the result register does not stall; each passes an input
// register, the compare-and-update logic of the decode core and, when it ends a timestep with a
// new class, a result register.
// Reset clears the valid flags of both stream registers and the decoder state, and sets the registers to defaults.
// A stalled output register holds its result; the input register keeps
// accepting as long as the core can retire its item.
module ctc_greedy_decoder_top #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_STEPS   = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [15:0] score, [24:16] decode_steps, [31:25] zero
    input  logic [ctcgd_pkg::S_TDATA_W-1:0]        s_tdata,
    // [0] sequence_start
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [6:0] class_index, [22:7] class_score, [23] zero
    output logic [ctcgd_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ctcgd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ctcgd_pkg::REG_W-1:0]            cfg_data
);
    import ctcgd_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;

    result_t core_result;
    logic    core_emit;
    logic    fire;

    // The core retires its item when the result register is free or draining.
    assign fire      = item_valid_reg && (!result_valid_reg || m_tready);
    assign s_tready  = !item_valid_reg || fire;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_classes    <= REG_W'(37);
            cfg_reg.padding_index  <= REG_W'(CLASS_LIMIT);
            cfg_reg.ignore_index_a <= REG_W'(CLASS_LIMIT);
            cfg_reg.ignore_index_b <= REG_W'(CLASS_LIMIT);
            cfg_reg.ignore_index_c <= REG_W'(CLASS_LIMIT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_CLASSES:    cfg_reg.num_classes    <= cfg_data;
                CFG_PADDING_INDEX:  cfg_reg.padding_index  <= cfg_data;
                CFG_IGNORE_INDEX_A: cfg_reg.ignore_index_a <= cfg_data;
                CFG_IGNORE_INDEX_B: cfg_reg.ignore_index_b <= cfg_data;
                CFG_IGNORE_INDEX_C: cfg_reg.ignore_index_c <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (s_tready)
            item_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.score          <= s_tdata[SCORE_W-1:0];
            item_reg.decode_steps   <= s_tdata[SCORE_W+STEPS_W-1:SCORE_W];
            item_reg.sequence_start <= s_tuser;
        end
    end

    ctcgd_core #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (item_reg),
        .fire   (fire),
        .emit   (core_emit),
        .result (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (fire)
            result_valid_reg <= core_emit;
        else if (m_tready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && core_emit)
            result_reg <= core_result;
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = {1'b0, result_reg.class_score, result_reg.class_index};

endmodule

// File: src/ctcgd_core.sv
// Decode core: running maximum per timestep, repeat and ignore filtering.
module ctcgd_core #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_STEPS   = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctcgd_pkg::cfg_t  cfg,
    input  ctcgd_pkg::item_t item,
    input  logic             fire,
    output logic             emit,
    output ctcgd_pkg::result_t result
);
    import ctcgd_pkg::*;

    // Effective class count and step limit bounds.
    localparam int NMAX     = (MAX_CLASSES < CLASS_LIMIT) ? MAX_CLASSES : CLASS_LIMIT;
    localparam int STEP_MAX = (1 << STEPS_W) - 1;
    localparam int STEP_CAP = (MAX_STEPS < STEP_MAX) ? MAX_STEPS : STEP_MAX;
    localparam int STEP_W   = $clog2(STEP_CAP + 1);

    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [CLASS_W-1:0] best_index_reg, best_index_next;
    logic [CLASS_W-1:0] class_count_reg, class_count_next;
    logic [REG_W-1:0]   previous_class_reg, previous_class_next;
    logic [STEP_W-1:0]  step_count_reg, step_count_next;
    logic [STEP_W-1:0]  steps_limit_reg, steps_limit_next;

    logic [REG_W-1:0]   n_eff;
    logic [CLASS_W-1:0] count_cur;
    logic [STEP_W-1:0]  step_cur;
    logic [REG_W-1:0]   prev_cur;
    logic [REG_W-1:0]   count_plus;
    logic               take;
    logic               last;
    logic               ignored;

    // Clamp the configured class count into its usable range.
    always_comb
    begin
        if (cfg.num_classes == '0)
            n_eff = REG_W'(1);
        else if (cfg.num_classes > REG_W'(NMAX))
            n_eff = REG_W'(NMAX);
        else
            n_eff = cfg.num_classes;
    end

    // Compare-and-update for one score, with end-of-timestep decision.
    always_comb
    begin
        best_score_next     = best_score_reg;
        best_index_next     = best_index_reg;
        class_count_next    = class_count_reg;
        previous_class_next = previous_class_reg;
        step_count_next     = step_count_reg;
        steps_limit_next    = steps_limit_reg;
        emit                = 1'b0;

        // A sequence start drops any partial timestep.
        if (item.sequence_start)
        begin
            if (item.decode_steps > STEPS_W'(STEP_CAP))
                steps_limit_next = STEP_W'(STEP_CAP);
            else
                steps_limit_next = STEP_W'(item.decode_steps);
            count_cur = '0;
            step_cur  = '0;
            prev_cur  = cfg.padding_index;
        end
        else
        begin
            count_cur = class_count_reg;
            step_cur  = step_count_reg;
            prev_cur  = previous_class_reg;
        end

        // A count at or past the current timestep length restarts the timestep.
        if ({1'b0, count_cur} >= n_eff)
            count_cur = '0;

        take = (count_cur == '0) || (item.score > best_score_reg);
        if (take)
        begin
            best_score_next = item.score;
            best_index_next = count_cur;
        end

        count_plus = {1'b0, count_cur} + REG_W'(1);
        last       = count_plus >= n_eff;
        ignored    = ({1'b0, best_index_next} == cfg.ignore_index_a) ||
                     ({1'b0, best_index_next} == cfg.ignore_index_b) ||
                     ({1'b0, best_index_next} == cfg.ignore_index_c);

        previous_class_next = prev_cur;
        step_count_next     = step_cur;
        if (last)
        begin
            if (step_cur < steps_limit_next)
            begin
                emit = ({1'b0, best_index_next} != prev_cur) && !ignored;
                previous_class_next = {1'b0, best_index_next};
                step_count_next     = step_cur + STEP_W'(1);
            end
            class_count_next = '0;
        end
        else
        begin
            class_count_next = count_plus[CLASS_W-1:0];
        end

        result.class_index = best_index_next;
        result.class_score = best_score_next;
    end

    // Decoder state, updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg     <= '0;
            best_index_reg     <= '0;
            class_count_reg    <= '0;
            previous_class_reg <= REG_W'(CLASS_LIMIT);
            step_count_reg     <= '0;
            steps_limit_reg    <= '0;
        end
        else if (fire)
        begin
            best_score_reg     <= best_score_next;
            best_index_reg     <= best_index_next;
            class_count_reg    <= class_count_next;
            previous_class_reg <= previous_class_next;
            step_count_reg     <= step_count_next;
            steps_limit_reg    <= steps_limit_next;
        end
    end

endmodule
